>>> hw/rtl/fcrn_pkg.sv
`timescale 1ns / 1ps

package fcrn_pkg;

    localparam int COMPONENTS = 4;
    localparam int COMP_W     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam int IN_W       = 32;
    localparam int ACC_W      = 64;
    localparam int ROOT_W     = ACC_W / 2;
    localparam int BIT_W      = $clog2(ROOT_W);
    localparam int RES_W      = 48;

    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [RES_W-1:0] t_res;

    localparam t_acc OUT_MAX = t_acc'({RES_W{1'b1}});

    // mode code 3 falls through to the maximum reduction
    typedef enum logic [1:0] {
        MODE_ABS = 2'd0,
        MODE_SQR = 2'd1,
        MODE_MAX = 2'd2
    } t_mode;

    typedef struct packed {
        logic  take;    // capture a new cell into the difference stage
        logic  upd;     // accumulate the cell sitting in the square stage
        logic  last;    // that cell closes the run
        t_mode mode;    // reduction applied to that cell
    } t_lane_ctl;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_ROOT,
        MS_LOAD
    } t_merge_state;

endpackage

>>> hw/rtl/fcrn_lane.sv
`timescale 1ns / 1ps

module fcrn_lane import fcrn_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_lane_ctl       i_ctl,
    input  logic [IN_W-1:0] i_new,
    input  logic [IN_W-1:0] i_old,
    output t_acc            o_sum
);

    localparam int SW = SAMPLE_WIDTH;

    logic signed [SW:0]   w_diff;
    logic [SW-1:0]        w_mag;
    logic [SW-1:0]        r_mag;
    logic [SW-1:0]        r_mag_b;
    logic [2*SW-1:0]      r_sq;
    t_acc                 r_acc;
    t_acc                 r_result;
    t_acc                 n_acc;
    t_acc                 w_mag64;
    t_acc                 w_sq64;
    t_acc                 w_abs_sum;
    logic [ACC_W:0]       w_sq_sum;

    // low SW bits of each sample, sign extended by one bit before the subtract
    assign w_diff = $signed({i_new[SW-1], i_new[SW-1:0]})
                  - $signed({i_old[SW-1], i_old[SW-1:0]});
    assign w_mag  = w_diff[SW] ? SW'(-w_diff) : w_diff[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_mag <= w_mag;
        end
        r_mag_b <= r_mag;
        r_sq    <= r_mag * r_mag;
    end

    assign w_mag64   = t_acc'(r_mag_b);
    assign w_sq64    = t_acc'(r_sq);
    assign w_abs_sum = r_acc + w_mag64;
    assign w_sq_sum  = {1'b0, r_acc} + {1'b0, w_sq64};

    always_comb begin
        case (i_ctl.mode)
            MODE_ABS: n_acc = (r_acc > (OUT_MAX - w_mag64)) ? OUT_MAX : w_abs_sum;
            MODE_SQR: n_acc = w_sq_sum[ACC_W] ? '1 : w_sq_sum[ACC_W-1:0];
            default:  n_acc = (w_mag64 > r_acc) ? w_mag64 : r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.upd) begin
            r_acc <= i_ctl.last ? '0 : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && i_ctl.last) begin
            r_result <= n_acc;
        end
    end

    assign o_sum = r_result;

endmodule

>>> hw/rtl/fcrn_merge.sv
`timescale 1ns / 1ps

module fcrn_merge import fcrn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_root,
    input  t_acc  i_sum [COMPONENTS],
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res [COMPONENTS],
    output logic  o_loaded
);

    t_merge_state        r_state;
    t_merge_state        n_state;
    t_acc                r_work [COMPONENTS];
    logic [ROOT_W:0]     r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [BIT_W-1:0]    r_bit;
    logic [COMP_W-1:0]   r_comp;
    logic                r_out_valid;
    t_res                r_res [COMPONENTS];
    logic [ROOT_W+2:0]   w_rem_sh;
    logic [ROOT_W+2:0]   w_trial;
    logic [ROOT_W+2:0]   w_rem_sub;
    logic                w_fits;
    logic [ROOT_W-1:0]   w_root_nx;
    logic                w_bit_last;
    logic                w_comp_last;
    logic                w_out_free;

    // bit-per-cycle restoring square root on r_work[0]; the array rotates
    // after each component so the root unit always sees entry 0
    assign w_rem_sh    = {r_rem, r_work[0][ACC_W-1 -: 2]};
    assign w_trial     = {1'b0, r_root, 2'b01};
    assign w_rem_sub   = w_rem_sh - w_trial;
    assign w_fits      = (w_rem_sh >= w_trial);
    assign w_root_nx   = {r_root[ROOT_W-2:0], w_fits};
    assign w_bit_last  = (r_bit == BIT_W'(ROOT_W - 1));
    assign w_comp_last = (r_comp == COMP_W'(COMPONENTS - 1));
    assign w_out_free  = !r_out_valid || i_ready;

    always_comb begin
        n_state  = r_state;
        o_loaded = 1'b0;
        unique case (r_state)
            MS_IDLE: begin
                if (i_start) begin
                    n_state = i_root ? MS_ROOT : MS_LOAD;
                end
            end
            MS_ROOT: begin
                if (w_bit_last && w_comp_last) begin
                    n_state = MS_LOAD;
                end
            end
            MS_LOAD: begin
                if (w_out_free) begin
                    o_loaded = 1'b1;
                    n_state  = MS_IDLE;
                end
            end
            default: n_state = MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= MS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_loaded) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MS_IDLE && i_start) begin
            r_work <= i_sum;
            r_rem  <= '0;
            r_root <= '0;
            r_bit  <= '0;
            r_comp <= '0;
        end else if (r_state == MS_ROOT) begin
            if (w_bit_last) begin
                for (int k = 0; k < COMPONENTS - 1; k++) begin
                    r_work[k] <= r_work[k+1];
                end
                r_work[COMPONENTS-1] <= t_acc'(w_root_nx);
                r_rem  <= '0;
                r_root <= '0;
                r_bit  <= '0;
                r_comp <= r_comp + 1'b1;
            end else begin
                r_work[0] <= {r_work[0][ACC_W-3:0], 2'b00};
                r_rem     <= w_fits ? w_rem_sub[ROOT_W:0] : w_rem_sh[ROOT_W:0];
                r_root    <= w_root_nx;
                r_bit     <= r_bit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_loaded) begin
            for (int k = 0; k < COMPONENTS; k++) begin
                r_res[k] <= (r_work[k] > OUT_MAX) ? OUT_MAX[RES_W-1:0]
                                                  : r_work[k][RES_W-1:0];
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == MS_IDLE))
        else $error("merge started while busy");

    a_root_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == MS_ROOT && w_bit_last && w_comp_last) |=> (r_state == MS_LOAD))
        else $error("root pass did not hand over to load");

endmodule

>>> hw/rtl/four_component_residual_norm_unit.sv
`timescale 1ns / 1ps

// Residual norm over a run of cells. Each cell transfer carries new and old
// values of four components; four lanes take one cell per cycle, form the
// difference and update their running reduction (absolute sum, sum of squares
// or maximum, per the mode register). A cell marked final closes the run: the
// lanes fold it in through their difference and square stages, then the merge
// stage saturates the sums to Q32.16 and loads the output register. In the
// squares mode the merge runs one shared restoring square-root unit, one root
// bit per cycle, over the components in turn. A final cell holds off input
// until the merge has loaded the output register, longer while the previous
// result still waits there. Ordinary cells stream at one per cycle, and new
// cells are taken while a result waits in the output register. Write the mode
// only while the block is idle.

module four_component_residual_norm_unit import fcrn_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [IN_W-1:0] i_new_q0,
    input  logic signed [IN_W-1:0] i_new_q1,
    input  logic signed [IN_W-1:0] i_new_q2,
    input  logic signed [IN_W-1:0] i_new_q3,
    input  logic signed [IN_W-1:0] i_old_q0,
    input  logic signed [IN_W-1:0] i_old_q1,
    input  logic signed [IN_W-1:0] i_old_q2,
    input  logic signed [IN_W-1:0] i_old_q3,
    input  logic                   i_final_cell,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [RES_W-1:0]       o_residual_0,
    output logic [RES_W-1:0]       o_residual_1,
    output logic [RES_W-1:0]       o_residual_2,
    output logic [RES_W-1:0]       o_residual_3
);

    t_mode           r_mode;
    logic            r_busy;
    logic            r_va;
    logic            r_la;
    t_mode           r_ma;
    logic            r_vb;
    logic            r_lb;
    t_mode           r_mb;
    logic            r_done;
    logic            r_done_root;
    logic            w_take;
    logic            w_loaded;
    t_lane_ctl       w_ctl;
    logic [IN_W-1:0] w_new [COMPONENTS];
    logic [IN_W-1:0] w_old [COMPONENTS];
    t_acc            w_sum [COMPONENTS];
    t_res            w_res [COMPONENTS];

    assign o_ready = !r_busy;
    assign w_take  = i_valid && o_ready;

    assign w_new[0] = i_new_q0;
    assign w_new[1] = i_new_q1;
    assign w_new[2] = i_new_q2;
    assign w_new[3] = i_new_q3;
    assign w_old[0] = i_old_q0;
    assign w_old[1] = i_old_q1;
    assign w_old[2] = i_old_q2;
    assign w_old[3] = i_old_q3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ABS;
            r_busy      <= 1'b0;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_mode'(i_cfg_data);
            end
            // one run closes at a time; reopen once the result is loaded
            if (w_take && i_final_cell) begin
                r_busy <= 1'b1;
            end else if (w_loaded) begin
                r_busy <= 1'b0;
            end
            r_va   <= w_take;
            r_vb   <= r_va;
            r_done <= r_vb && r_lb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_la        <= i_final_cell;
        r_ma        <= r_mode;
        r_lb        <= r_la;
        r_mb        <= r_ma;
        r_done_root <= (r_mb == MODE_SQR);
    end

    assign w_ctl.take = w_take;
    assign w_ctl.upd  = r_vb;
    assign w_ctl.last = r_lb;
    assign w_ctl.mode = r_mb;

    for (genvar g = 0; g < COMPONENTS; g++) begin : g_lane
        fcrn_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_new   (w_new[g]),
            .i_old   (w_old[g]),
            .o_sum   (w_sum[g])
        );
    end

    fcrn_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_done),
        .i_root   (r_done_root),
        .i_sum    (w_sum),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res    (w_res),
        .o_loaded (w_loaded)
    );

    assign o_residual_0 = w_res[0];
    assign o_residual_1 = w_res[1];
    assign o_residual_2 = w_res[2];
    assign o_residual_3 = w_res[3];

    a_final_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_final_cell) |=> !o_ready)
        else $error("input still open after a final cell");

    a_one_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_va && r_la, r_vb && r_lb, r_done}) <= 1)
        else $error("two final cells in the lane pipeline");

endmodule
